@@ sv/cbop_pkg.sv @@
// ----------------------------------------------------------------------------
// cbop_pkg
// Shared types, codes and sizes for the capture buffer ownership pool.
// ----------------------------------------------------------------------------
package cbop_pkg;

	localparam int NUM_BUFFERS = 8;
	localparam int SLOT_W      = $clog2(NUM_BUFFERS);
	localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);

	localparam int CMD_W      = 3;
	localparam int ID_W       = 64;
	localparam int SLOT_IN_W  = 8;
	localparam int ERR_W      = 4;
	localparam int SLOT_OUT_W = 3;
	localparam int SEQ_W      = 32;

	typedef logic [1:0] own_t;
	localparam own_t OWN_FREE     = 2'd0;
	localparam own_t OWN_DMA      = 2'd1;
	localparam own_t OWN_READY    = 2'd2;
	localparam own_t OWN_ENCODING = 2'd3;

	typedef logic [CMD_W-1:0] cmd_code_t;
	localparam cmd_code_t CMD_BEGIN   = 3'd0;
	localparam cmd_code_t CMD_ACQUIRE = 3'd1;
	localparam cmd_code_t CMD_FULL    = 3'd2;
	localparam cmd_code_t CMD_STOP    = 3'd3;
	localparam cmd_code_t CMD_QUIESCE = 3'd4;
	localparam cmd_code_t CMD_TAKE    = 3'd5;
	localparam cmd_code_t CMD_RELEASE = 3'd6;
	localparam cmd_code_t CMD_FAULT   = 3'd7;

	typedef logic [ERR_W-1:0] err_t;
	localparam err_t ERR_NONE     = 4'd0;
	localparam err_t ERR_OVERFLOW = 4'd1;
	localparam err_t ERR_CAPTURE  = 4'd2;

	localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

	typedef struct packed {
		cmd_code_t              cmd;
		logic [ID_W-1:0]        session_id;
		logic [SLOT_IN_W-1:0]   slot_in;
		logic                   forced;
		err_t                   fault_code;
	} item_t;

	typedef struct packed {
		logic                   ok;
		logic [SLOT_OUT_W-1:0]  slot_out;
		logic [SEQ_W-1:0]       seq_out;
		logic                   drained;
		err_t                   error_out;
		logic                   stop_pending;
	} result_t;

	typedef struct packed {
		logic                   clear;
		logic                   push;
		logic                   pop;
		logic [SLOT_W-1:0]      push_slot;
	} fifo_ctl_t;

endpackage

@@ sv/cbop_ready_fifo.sv @@
// ----------------------------------------------------------------------------
// cbop_ready_fifo
// Circular queue of ready slot indexes, oldest at the head.
// ----------------------------------------------------------------------------
module cbop_ready_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbop_pkg::fifo_ctl_t           ctl,
	output logic [cbop_pkg::SLOT_W-1:0]   head_slot,
	output logic [cbop_pkg::CNT_W-1:0]    count
);

	logic [cbop_pkg::SLOT_W-1:0] entry_q [cbop_pkg::NUM_BUFFERS];
	logic [cbop_pkg::SLOT_W-1:0] head_q;
	logic [cbop_pkg::CNT_W-1:0]  count_q;
	logic [cbop_pkg::SLOT_W:0]   tail_sum;
	logic [cbop_pkg::SLOT_W:0]   head_sum;
	logic [cbop_pkg::SLOT_W-1:0] tail;
	logic [cbop_pkg::SLOT_W-1:0] head_next;

	always_comb begin
		tail_sum = (cbop_pkg::SLOT_W+1)'(head_q) + (cbop_pkg::SLOT_W+1)'(count_q);
		if (tail_sum >= (cbop_pkg::SLOT_W+1)'(cbop_pkg::NUM_BUFFERS)) begin
			tail = cbop_pkg::SLOT_W'(tail_sum - (cbop_pkg::SLOT_W+1)'(cbop_pkg::NUM_BUFFERS));
		end else begin
			tail = cbop_pkg::SLOT_W'(tail_sum);
		end
		head_sum = (cbop_pkg::SLOT_W+1)'(head_q) + (cbop_pkg::SLOT_W+1)'(1);
		if (head_sum >= (cbop_pkg::SLOT_W+1)'(cbop_pkg::NUM_BUFFERS)) begin
			head_next = '0;
		end else begin
			head_next = cbop_pkg::SLOT_W'(head_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (ctl.push) begin
			count_q <= count_q + cbop_pkg::CNT_W'(1);
		end else if (ctl.pop) begin
			head_q  <= head_next;
			count_q <= count_q - cbop_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clear) begin
			entry_q[tail] <= ctl.push_slot;
		end
	end

	assign head_slot = entry_q[head_q];
	assign count     = count_q;

endmodule

@@ sv/cbop_core.sv @@
// ----------------------------------------------------------------------------
// cbop_core
// Session, slot ownership and sequence state; single-pass command decode.
// ----------------------------------------------------------------------------
module cbop_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  cbop_pkg::item_t               item,
	input  logic [cbop_pkg::SLOT_W-1:0]   head_slot,
	input  logic [cbop_pkg::CNT_W-1:0]    fifo_count,
	output cbop_pkg::fifo_ctl_t           fifo_ctl,
	output cbop_pkg::result_t             res
);

	logic [cbop_pkg::ID_W-1:0]   active_id_q;
	logic                        running_q;
	logic                        quiescent_q;
	logic                        stop_q;
	cbop_pkg::err_t              err_q;
	cbop_pkg::own_t              owner_q [cbop_pkg::NUM_BUFFERS];
	logic [cbop_pkg::SEQ_W-1:0]  slot_seq_q [cbop_pkg::NUM_BUFFERS];
	logic [cbop_pkg::SEQ_W-1:0]  seq_cnt_q;

	logic [cbop_pkg::ID_W-1:0]   active_n;
	logic                        running_n;
	logic                        quiescent_n;
	logic                        stop_n;
	cbop_pkg::err_t              err_n;
	cbop_pkg::own_t              owner_n [cbop_pkg::NUM_BUFFERS];
	logic [cbop_pkg::SEQ_W-1:0]  seq_cnt_n;
	logic                        seq_wr;
	logic [cbop_pkg::CNT_W-1:0]  count_n;
	cbop_pkg::fifo_ctl_t         ctl_c;

	logic                        id_match;
	logic                        id_match_n;
	logic                        all_free;
	logic                        all_free_n;
	logic                        slot_ok;
	logic [cbop_pkg::SLOT_W-1:0] idx;
	logic                        found;
	logic [cbop_pkg::SLOT_W-1:0] free_idx;
	logic                        fault;
	cbop_pkg::err_t              fault_code;

	assign idx     = item.slot_in[cbop_pkg::SLOT_W-1:0];
	assign slot_ok = item.slot_in < cbop_pkg::SLOT_IN_W'(cbop_pkg::NUM_BUFFERS);

	always_comb begin
		all_free = 1'b1;
		found    = 1'b0;
		free_idx = '0;
		for (int i = 0; i < cbop_pkg::NUM_BUFFERS; i++) begin
			if (owner_q[i] != cbop_pkg::OWN_FREE) begin
				all_free = 1'b0;
			end
			if (!found && owner_q[i] == cbop_pkg::OWN_FREE) begin
				found    = 1'b1;
				free_idx = cbop_pkg::SLOT_W'(i);
			end
		end
	end

	assign id_match = (item.session_id != '0) && (item.session_id == active_id_q);

	always_comb begin
		active_n    = active_id_q;
		running_n   = running_q;
		quiescent_n = quiescent_q;
		stop_n      = stop_q;
		err_n       = err_q;
		seq_cnt_n   = seq_cnt_q;
		seq_wr      = 1'b0;
		ctl_c       = '0;
		fault       = 1'b0;
		fault_code  = cbop_pkg::ERR_NONE;
		res         = '0;
		for (int i = 0; i < cbop_pkg::NUM_BUFFERS; i++) begin
			owner_n[i] = owner_q[i];
		end

		if (item.cmd == cbop_pkg::CMD_BEGIN) begin
			if (item.session_id != '0 && !running_q && fifo_count == '0 && all_free) begin
				active_n    = item.session_id;
				running_n   = 1'b1;
				quiescent_n = 1'b0;
				stop_n      = 1'b0;
				err_n       = cbop_pkg::ERR_NONE;
				seq_cnt_n   = '0;
				ctl_c.clear = 1'b1;
				res.ok      = 1'b1;
			end
		end else if (id_match) begin
			case (item.cmd)
				cbop_pkg::CMD_ACQUIRE: begin
					if (running_q && !quiescent_q) begin
						if (found) begin
							owner_n[free_idx] = cbop_pkg::OWN_DMA;
							res.ok            = 1'b1;
							res.slot_out      = cbop_pkg::SLOT_OUT_W'(free_idx);
						end else begin
							fault      = 1'b1;
							fault_code = cbop_pkg::ERR_OVERFLOW;
						end
					end
				end
				cbop_pkg::CMD_FULL: begin
					if (!running_q || quiescent_q || !slot_ok ||
					    owner_q[idx] != cbop_pkg::OWN_DMA ||
					    fifo_count >= cbop_pkg::CNT_W'(cbop_pkg::NUM_BUFFERS) ||
					    seq_cnt_q == cbop_pkg::SEQ_MAX) begin
						fault      = 1'b1;
						fault_code = cbop_pkg::ERR_OVERFLOW;
					end else begin
						owner_n[idx]    = cbop_pkg::OWN_READY;
						seq_cnt_n       = seq_cnt_q + cbop_pkg::SEQ_W'(1);
						seq_wr          = 1'b1;
						ctl_c.push      = 1'b1;
						ctl_c.push_slot = idx;
						res.ok          = 1'b1;
					end
				end
				cbop_pkg::CMD_STOP: begin
					stop_n = 1'b1;
					res.ok = 1'b1;
				end
				cbop_pkg::CMD_QUIESCE: begin
					if (item.forced || !stop_q) begin
						fault      = 1'b1;
						fault_code = cbop_pkg::ERR_CAPTURE;
					end
					quiescent_n = 1'b1;
					running_n   = 1'b0;
					for (int i = 0; i < cbop_pkg::NUM_BUFFERS; i++) begin
						if (owner_q[i] == cbop_pkg::OWN_DMA) begin
							owner_n[i] = cbop_pkg::OWN_FREE;
						end
					end
					res.ok = 1'b1;
				end
				cbop_pkg::CMD_TAKE: begin
					if (fifo_count != '0) begin
						if ((cbop_pkg::SLOT_W+1)'(head_slot) >=
						    (cbop_pkg::SLOT_W+1)'(cbop_pkg::NUM_BUFFERS) ||
						    owner_q[head_slot] != cbop_pkg::OWN_READY) begin
							fault      = 1'b1;
							fault_code = cbop_pkg::ERR_OVERFLOW;
						end else begin
							ctl_c.pop          = 1'b1;
							owner_n[head_slot] = cbop_pkg::OWN_ENCODING;
							res.ok             = 1'b1;
							res.slot_out       = cbop_pkg::SLOT_OUT_W'(head_slot);
							res.seq_out        = slot_seq_q[head_slot];
						end
					end
				end
				cbop_pkg::CMD_RELEASE: begin
					if (!slot_ok || owner_q[idx] != cbop_pkg::OWN_ENCODING) begin
						fault      = 1'b1;
						fault_code = cbop_pkg::ERR_OVERFLOW;
					end else begin
						owner_n[idx] = cbop_pkg::OWN_FREE;
						res.ok       = 1'b1;
					end
				end
				cbop_pkg::CMD_FAULT: begin
					if (item.fault_code != cbop_pkg::ERR_NONE) begin
						fault      = 1'b1;
						fault_code = item.fault_code;
						res.ok     = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// only the first error sticks; any fault forces a stop
		if (fault) begin
			if (err_q == cbop_pkg::ERR_NONE) begin
				err_n = fault_code;
			end
			stop_n = 1'b1;
		end

		if (ctl_c.clear) begin
			count_n = '0;
		end else if (ctl_c.push) begin
			count_n = fifo_count + cbop_pkg::CNT_W'(1);
		end else if (ctl_c.pop) begin
			count_n = fifo_count - cbop_pkg::CNT_W'(1);
		end else begin
			count_n = fifo_count;
		end

		all_free_n = 1'b1;
		for (int i = 0; i < cbop_pkg::NUM_BUFFERS; i++) begin
			if (owner_n[i] != cbop_pkg::OWN_FREE) begin
				all_free_n = 1'b0;
			end
		end
		id_match_n = (item.session_id != '0) && (item.session_id == active_n);

		res.drained      = id_match_n && quiescent_n && count_n == '0 && all_free_n;
		res.error_out    = err_n;
		res.stop_pending = stop_n;
	end

	assign fifo_ctl = en ? ctl_c : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_id_q <= '0;
			running_q   <= 1'b0;
			quiescent_q <= 1'b0;
			stop_q      <= 1'b0;
			err_q       <= cbop_pkg::ERR_NONE;
			seq_cnt_q   <= '0;
			for (int i = 0; i < cbop_pkg::NUM_BUFFERS; i++) begin
				owner_q[i] <= cbop_pkg::OWN_FREE;
			end
		end else if (en) begin
			active_id_q <= active_n;
			running_q   <= running_n;
			quiescent_q <= quiescent_n;
			stop_q      <= stop_n;
			err_q       <= err_n;
			seq_cnt_q   <= seq_cnt_n;
			for (int i = 0; i < cbop_pkg::NUM_BUFFERS; i++) begin
				owner_q[i] <= owner_n[i];
			end
		end
	end

	// a slot's stamp is only read after a full has written it
	always_ff @(posedge clk) begin
		if (en && seq_wr) begin
			slot_seq_q[idx] <= seq_cnt_n;
		end
	end

endmodule

@@ sv/capture_buffer_ownership_pool.sv @@
// ----------------------------------------------------------------------------
// capture_buffer_ownership_pool
// Pool of capture buffers owned by one session: begin, acquire, full, take,
// release, stop, quiesce and fault commands with an ordered ready queue.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   request   req_valid / req_stall  cmd, session_id, slot_in, forced, fault_code
//   response  rsp_valid / rsp_stall  ok, slot_out, seq_out, drained, error_out,
//                                    stop_pending
//
// One command per cycle while req_stall is low; a command passes the input
// register and then the result register before its response is valid. The decode and
// slot-table update is one combinational pass between input and result regs.
// Reset clears session, ownership and queue state at once; no clearing pass.
// rsp_stall on a full result raises req_stall for a waiting command, same cycle.
// ----------------------------------------------------------------------------
module capture_buffer_ownership_pool (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [cbop_pkg::CMD_W-1:0]        cmd,
	input  logic [cbop_pkg::ID_W-1:0]         session_id,
	input  logic [cbop_pkg::SLOT_IN_W-1:0]    slot_in,
	input  logic                              forced,
	input  logic [cbop_pkg::ERR_W-1:0]        fault_code,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              ok,
	output logic [cbop_pkg::SLOT_OUT_W-1:0]   slot_out,
	output logic [cbop_pkg::SEQ_W-1:0]        seq_out,
	output logic                              drained,
	output logic [cbop_pkg::ERR_W-1:0]        error_out,
	output logic                              stop_pending
);

	logic                         valid_s1;
	cbop_pkg::item_t              item_s1;
	logic                         rsp_valid_q;
	cbop_pkg::result_t            result_q;
	cbop_pkg::result_t            res;
	cbop_pkg::fifo_ctl_t          fifo_ctl;
	logic [cbop_pkg::SLOT_W-1:0]  head_slot;
	logic [cbop_pkg::CNT_W-1:0]   fifo_count;
	logic                         advance;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1.cmd        <= cmd;
			item_s1.session_id <= session_id;
			item_s1.slot_in    <= slot_in;
			item_s1.forced     <= forced;
			item_s1.fault_code <= fault_code;
		end
	end

	cbop_ready_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fifo_ctl),
		.head_slot (head_slot),
		.count     (fifo_count)
	);

	cbop_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.item       (item_s1),
		.head_slot  (head_slot),
		.fifo_count (fifo_count),
		.fifo_ctl   (fifo_ctl),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign ok           = result_q.ok;
	assign slot_out     = result_q.slot_out;
	assign seq_out      = result_q.seq_out;
	assign drained      = result_q.drained;
	assign error_out    = result_q.error_out;
	assign stop_pending = result_q.stop_pending;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid_q && rsp_stall)
		else $error("request stalled without a held result");

	a_slot_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (slot_out != '0 || seq_out != '0)) |-> ok)
		else $error("slot or sequence reported on a failed command");

	a_error_forces_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && error_out != cbop_pkg::ERR_NONE) |-> stop_pending)
		else $error("latched error without a pending stop");

	a_drained_not_ok_acquire: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.drained) |-> fifo_count == '0 || fifo_ctl.pop)
		else $error("drained reported with ready slots queued");

endmodule

@@ tb/sv/pool_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_scoreboard_pkg
// Ownership tracker and response checker for the capture buffer pool. It
// keeps its own copy of the session, slot table and ready queue, works out
// the response of every command transfer, and compares responses in order.
// ----------------------------------------------------------------------------
package pool_scoreboard_pkg;

	import cbop_pkg::*;

	class pool_scoreboard;
		logic [ID_W-1:0]   active_id;
		bit                running;
		bit                quiescent;
		bit                stop_req;
		err_t              err_latch;
		own_t              owner [NUM_BUFFERS];
		logic [SEQ_W-1:0]  slot_seq [NUM_BUFFERS];
		logic [SLOT_W-1:0] ready_q [NUM_BUFFERS];
		logic [SLOT_W-1:0] head;
		logic [CNT_W-1:0]  count;
		logic [SEQ_W-1:0]  seq_cnt;
		result_t           expected_rsp [$];
		int                errors;

		function new();
			clear_state();
			errors = 0;
		endfunction

		function void clear_state();
			active_id = '0;
			running = 1'b0;
			quiescent = 1'b0;
			stop_req = 1'b0;
			err_latch = ERR_NONE;
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				owner[i] = OWN_FREE;
				slot_seq[i] = '0;
				ready_q[i] = '0;
			end
			head = '0;
			count = '0;
			seq_cnt = '0;
		endfunction

		function bit id_ok(logic [ID_W-1:0] id);
			return id != '0 && id == active_id;
		endfunction

		function bit pool_empty();
			foreach (owner[i])
				if (owner[i] != OWN_FREE)
					return 1'b0;
			return 1'b1;
		endfunction

		// first error wins; any error forces a stop
		function void flag_error(err_t code);
			if (code == ERR_NONE)
				return;
			if (err_latch == ERR_NONE)
				err_latch = code;
			stop_req = 1'b1;
		endfunction

		function void note_command(item_t it);
			result_t r;
			bit grabbed;
			logic [SLOT_W-1:0] s;
			logic [SLOT_W-1:0] tail;
			r = '0;
			grabbed = 1'b0;
			if (it.cmd == CMD_BEGIN) begin
				if (it.session_id != '0 && !running && count == 0 && pool_empty()) begin
					clear_state();
					active_id = it.session_id;
					running = 1'b1;
					r.ok = 1'b1;
				end
			end else if (id_ok(it.session_id)) begin
				s = it.slot_in[SLOT_W-1:0];
				case (it.cmd)
				CMD_ACQUIRE: begin
					if (running && !quiescent) begin
						for (int i = 0; i < NUM_BUFFERS && !grabbed; i++)
							if (owner[i] == OWN_FREE) begin
								owner[i] = OWN_DMA;
								grabbed = 1'b1;
								r.ok = 1'b1;
								r.slot_out = SLOT_OUT_W'(i);
							end
						if (!grabbed)
							flag_error(ERR_OVERFLOW);
					end
				end
				CMD_FULL: begin
					if (!running || quiescent || it.slot_in >= NUM_BUFFERS ||
							count >= NUM_BUFFERS || seq_cnt == SEQ_MAX)
						flag_error(ERR_OVERFLOW);
					else if (owner[s] != OWN_DMA)
						flag_error(ERR_OVERFLOW);
					else begin
						owner[s] = OWN_READY;
						seq_cnt++;
						slot_seq[s] = seq_cnt;
						tail = head + count[SLOT_W-1:0];
						ready_q[tail] = s;
						count++;
						r.ok = 1'b1;
					end
				end
				CMD_STOP: begin
					stop_req = 1'b1;
					r.ok = 1'b1;
				end
				CMD_QUIESCE: begin
					if (it.forced || !stop_req)
						flag_error(ERR_CAPTURE);
					quiescent = 1'b1;
					running = 1'b0;
					foreach (owner[i])
						if (owner[i] == OWN_DMA)
							owner[i] = OWN_FREE;
					r.ok = 1'b1;
				end
				CMD_TAKE: begin
					if (count != 0) begin
						s = ready_q[head];
						if (owner[s] != OWN_READY)
							flag_error(ERR_OVERFLOW);
						else begin
							head++;
							count--;
							owner[s] = OWN_ENCODING;
							r.ok = 1'b1;
							r.slot_out = s;
							r.seq_out = slot_seq[s];
						end
					end
				end
				CMD_RELEASE: begin
					if (it.slot_in >= NUM_BUFFERS)
						flag_error(ERR_OVERFLOW);
					else if (owner[s] != OWN_ENCODING)
						flag_error(ERR_OVERFLOW);
					else begin
						owner[s] = OWN_FREE;
						r.ok = 1'b1;
					end
				end
				default: begin
					if (it.fault_code != ERR_NONE) begin
						flag_error(it.fault_code);
						r.ok = 1'b1;
					end
				end
				endcase
			end
			r.drained = id_ok(it.session_id) && quiescent && count == 0 && pool_empty();
			r.error_out = err_latch;
			r.stop_pending = stop_req;
			expected_rsp.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_response(result_t got);
			result_t want;
			if (expected_rsp.size() == 0) begin
				errors++;
				$display("%0t ns: response with no command outstanding", $time);
				return;
			end
			want = expected_rsp.pop_front();
			compare_field("ok", want.ok, got.ok);
			compare_field("slot_out", want.slot_out, got.slot_out);
			compare_field("seq_out", want.seq_out, got.seq_out);
			compare_field("drained", want.drained, got.drained);
			compare_field("error_out", want.error_out, got.error_out);
			compare_field("stop_pending", want.stop_pending, got.stop_pending);
		endfunction
	endclass

endpackage

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives session commands into the capture buffer pool: a directed pass over
// the corner cases, then random sessions of acquire, full, take and release
// with noise, each closed by quiesce, mostly after a stop and mostly followed
// by a drain. Both channels idle at random; every response is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb;

	import cbop_pkg::*;
	import pool_scoreboard_pkg::*;

	localparam int RANDOM_ITEMS   = 900;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [CMD_W-1:0]      cmd = '0;
	logic [ID_W-1:0]       session_id = '0;
	logic [SLOT_IN_W-1:0]  slot_in = '0;
	logic                  forced = 1'b0;
	logic [ERR_W-1:0]      fault_code = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic                  ok;
	logic [SLOT_OUT_W-1:0] slot_out;
	logic [SEQ_W-1:0]      seq_out;
	logic                  drained;
	logic [ERR_W-1:0]      error_out;
	logic                  stop_pending;

	pool_scoreboard sb = new();
	int items_sent = 0;
	int quiet_cycles = 0;

	capture_buffer_ownership_pool DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.session_id   (session_id),
		.slot_in      (slot_in),
		.forced       (forced),
		.fault_code   (fault_code),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.ok           (ok),
		.slot_out     (slot_out),
		.seq_out      (seq_out),
		.drained      (drained),
		.error_out    (error_out),
		.stop_pending (stop_pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// no idling on either side through one stretch of the random part
	function automatic bit idle_roll();
		return !(items_sent >= 400 && items_sent < 550) && ($urandom_range(99) < 26);
	endfunction

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall)
			sb.check_response({ok, slot_out, seq_out, drained, error_out, stop_pending});
		rsp_stall <= idle_roll();
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic send(item_t it);
		while (idle_roll()) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= it.cmd;
		session_id <= it.session_id;
		slot_in <= it.slot_in;
		forced <= it.forced;
		fault_code <= it.fault_code;
		do @(posedge clk); while (req_stall);
		sb.note_command(it);
		items_sent++;
	endtask

	task automatic issue(cmd_code_t c, logic [ID_W-1:0] id, logic [SLOT_IN_W-1:0] slot = '0,
			logic f = 1'b0, err_t code = ERR_NONE);
		send('{cmd: c, session_id: id, slot_in: slot, forced: f, fault_code: code});
	endtask

	task automatic hold_until_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic item_t rand_item(cmd_code_t c, logic [ID_W-1:0] id);
		item_t it;
		it.cmd = c;
		it.session_id = id;
		it.slot_in = SLOT_IN_W'($urandom_range(255));
		it.forced = 1'($urandom_range(1));
		it.fault_code = err_t'($urandom_range(15));
		return it;
	endfunction

	function automatic int pick_slot(own_t st);
		int hits[$];
		for (int i = 0; i < NUM_BUFFERS; i++)
			if (sb.owner[i] == st)
				hits.push_back(i);
		if (hits.size() == 0)
			return -1;
		return hits[$urandom_range(hits.size() - 1)];
	endfunction

	task automatic run_session();
		item_t it;
		int k;
		int s;
		logic [ID_W-1:0] id;
		id = {$urandom, $urandom};
		if ($urandom_range(9) == 0)
			send(rand_item(CMD_BEGIN, '0));
		send(rand_item(CMD_BEGIN, id));
		repeat ($urandom_range(4, 40)) begin
			k = $urandom_range(99);
			it = rand_item(CMD_ACQUIRE, sb.active_id);
			if (k < 30) begin
			end else if (k < 55) begin
				s = pick_slot(OWN_DMA);
				if (s < 0)
					it.cmd = CMD_ACQUIRE;
				else begin
					it.cmd = CMD_FULL;
					if ($urandom_range(19) != 0)
						it.slot_in = SLOT_IN_W'(s);
				end
			end else if (k < 75) begin
				it.cmd = CMD_TAKE;
			end else if (k < 90) begin
				s = pick_slot(OWN_ENCODING);
				if (s < 0)
					it.cmd = CMD_TAKE;
				else begin
					it.cmd = CMD_RELEASE;
					if ($urandom_range(19) != 0)
						it.slot_in = SLOT_IN_W'(s);
				end
			end else if (k < 94) begin
				it.cmd = cmd_code_t'($urandom_range(7));
				it.session_id = $urandom_range(1) ? '0 : {$urandom, $urandom};
			end else if (k < 97) begin
				it.cmd = CMD_FAULT;
			end else begin
				it.cmd = $urandom_range(1) ? CMD_STOP : CMD_BEGIN;
			end
			send(it);
		end
		if ($urandom_range(99) < 85)
			send(rand_item(CMD_STOP, sb.active_id));
		it = rand_item(CMD_QUIESCE, sb.active_id);
		it.forced = ($urandom_range(9) == 0);
		send(it);
		// an occasional session is left dirty so the next begin may be refused
		if ($urandom_range(19) != 0) begin
			while (sb.count != 0)
				send(rand_item(CMD_TAKE, sb.active_id));
			for (int i = 0; i < NUM_BUFFERS; i++)
				if (sb.owner[i] == OWN_ENCODING) begin
					it = rand_item(CMD_RELEASE, sb.active_id);
					it.slot_in = SLOT_IN_W'(i);
					send(it);
				end
		end
	endtask

	initial begin
		int sessions;
		int target;
		logic [ID_W-1:0] id_a;
		logic [ID_W-1:0] id_c;
		id_a = '1;
		id_c = {1'b1, {(ID_W-1){1'b0}}};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_BEGIN, '0);
		issue(CMD_BEGIN, id_a, '1, 1'b1, err_t'('1));
		issue(CMD_BEGIN, 64'd1);
		issue(CMD_ACQUIRE, id_a - 1);
		issue(CMD_TAKE, id_a);
		repeat (NUM_BUFFERS + 1)
			issue(CMD_ACQUIRE, id_a);
		issue(CMD_FULL, id_a, '1);
		issue(CMD_FULL, id_a, 8'd3);
		issue(CMD_FULL, id_a, 8'd0);
		issue(CMD_TAKE, id_a);
		issue(CMD_RELEASE, id_a, 8'd5);
		issue(CMD_RELEASE, id_a, 8'd3);
		issue(CMD_FAULT, id_a, '0, 1'b0, ERR_NONE);
		issue(CMD_FAULT, id_a, '0, 1'b0, err_t'('1));
		issue(CMD_STOP, id_a);
		issue(CMD_QUIESCE, id_a, '0, 1'b1);
		issue(CMD_ACQUIRE, id_a);
		issue(CMD_TAKE, id_a);
		issue(CMD_RELEASE, id_a, 8'd0);
		issue(CMD_BEGIN, 64'd1);
		issue(CMD_QUIESCE, 64'd1);
		issue(CMD_BEGIN, id_c);
		issue(CMD_FAULT, id_c, '0, 1'b0, err_t'(9));
		issue(CMD_QUIESCE, id_c);
		hold_until_idle();

		sessions = 0;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			run_session();
			sessions++;
			if (sessions % 6 == 5)
				hold_until_idle();
		end

		hold_until_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_rsp.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
